### rtl/rmca_pkg.sv
package rmca_pkg;

    localparam int POS_W  = 30;
    localparam int DATA_W = 32;
    localparam int ACC_W  = POS_W + 3;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic load_first;
        logic step;
        logic wrap;
        logic fin;
    } gap_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRAP,
        ST_FIN,
        ST_SEND
    } state_t;

endpackage

### rtl/rmca_cell.sv
module rmca_cell (
    input  logic                     clk,
    input  rmca_pkg::cell_ctl_t      ctl,
    input  logic [rmca_pkg::POS_W-1:0] pos,
    input  logic                     valid,
    input  logic                     left_keep,
    input  logic [rmca_pkg::POS_W-1:0] left_val,
    input  logic [rmca_pkg::POS_W-1:0] right_val,
    output logic [rmca_pkg::POS_W-1:0] val,
    output logic                     keep
);
    import rmca_pkg::*;

    logic [POS_W-1:0] val_reg;
    logic [POS_W-1:0] val_next;

    assign keep = valid && (val_reg <= pos);
    assign val  = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins)
        begin
            if (keep)
            begin
                val_next = val_reg;
            end
            else if (left_keep)
            begin
                val_next = pos;
            end
            else
            begin
                val_next = left_val;
            end
        end
        else if (ctl.shift)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### rtl/rmca_gap.sv
module rmca_gap (
    input  logic                       clk,
    input  rmca_pkg::gap_ctl_t         ctl,
    input  logic [rmca_pkg::POS_W-1:0] head,
    input  logic [rmca_pkg::POS_W-1:0] ring,
    output logic [rmca_pkg::POS_W-1:0] span
);
    import rmca_pkg::*;

    logic [POS_W-1:0]        first_reg, first_next;
    logic [POS_W-1:0]        prev_reg, prev_next;
    logic [POS_W-1:0]        maxg_reg, maxg_next;
    logic signed [ACC_W-1:0] wrap_reg, wrap_next;
    logic [POS_W-1:0]        span_reg, span_next;
    logic [POS_W-1:0]        gap;
    logic signed [ACC_W-1:0] maxg_s;
    logic signed [ACC_W-1:0] widest;
    logic signed [ACC_W-1:0] diff;

    assign gap    = head - prev_reg;
    assign maxg_s = $signed({3'b000, maxg_reg});
    assign widest = (wrap_reg > maxg_s) ? wrap_reg : maxg_s;
    assign diff   = $signed({3'b000, ring}) - widest;

    always_comb
    begin
        first_next = first_reg;
        prev_next  = prev_reg;
        maxg_next  = maxg_reg;
        wrap_next  = wrap_reg;
        span_next  = span_reg;
        if (ctl.load_first)
        begin
            first_next = head;
            prev_next  = head;
            maxg_next  = '0;
        end
        if (ctl.step)
        begin
            prev_next = head;
            if (gap > maxg_reg)
            begin
                maxg_next = gap;
            end
        end
        if (ctl.wrap)
        begin
            wrap_next = $signed({3'b000, ring}) - $signed({3'b000, prev_reg})
                        + $signed({3'b000, first_reg});
        end
        if (ctl.fin)
        begin
            span_next = (diff < 0) ? '0 : diff[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        prev_reg  <= prev_next;
        maxg_reg  <= maxg_next;
        wrap_reg  <= wrap_next;
        span_reg  <= span_next;
    end

    assign span = span_reg;

endmodule

### rtl/ring_min_covering_arc.sv
// ring_min_covering_arc
// positions on a ring arrive on the s_axis channel, one per beat; tlast
// marks the final point of a set. points are kept sorted in a row of
// MAX_POINTS insertion cells, one new point per cycle while idle.
// after the tlast beat the row shifts toward cell 0 and the gap unit walks
// the sorted points, one per cycle, then takes the wrap gap and the span.
// one result beat per set on m_axis: tdata carries min_span, tuser the
// overflow flag. s_axis_tready is low from the tlast beat through that
// walk until the result is loaded. points beyond MAX_POINTS are dropped
// and flag overflow. the result sits in an output register: a stalled
// receiver holds it while the next set loads; a second result waits
// until the first leaves. ring_size is written through cfg_wr_en /
// cfg_wr_data; the user must do so only while idle, as the block does
// not enforce it. reset empties the set, sets ring_size to 1 and drops
// any pending result (m_axis_tvalid low).
module ring_min_covering_arc #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [29:0] cfg_wr_data,    // ring_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // position[29:0], zero pad
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // min_span[29:0], zero pad
    output logic        m_axis_tuser    // overflow
);
    import rmca_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              ovf_reg, ovf_next;
    logic [POS_W-1:0]  ring_reg;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_span_reg, out_span_next;
    logic              out_ovf_reg, out_ovf_next;

    cell_ctl_t         cell_ctl;
    gap_ctl_t          gap_ctl;
    logic              accept;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  span;

    logic [POS_W-1:0]  cell_val  [MAX_POINTS];
    logic              cell_keep [MAX_POINTS];
    logic              cell_valid[MAX_POINTS];

    assign pos    = s_axis_tdata[POS_W-1:0];
    assign accept = s_axis_tvalid && s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            logic             lk;
            logic [POS_W-1:0] lv;
            logic [POS_W-1:0] rv;

            assign cell_valid[gi] = CNT_W'(gi) < count_reg;

            if (gi == 0)
            begin : g_head
                assign lk = 1'b1;
                assign lv = pos;
            end
            else
            begin : g_body
                assign lk = cell_keep[gi-1];
                assign lv = cell_val[gi-1];
            end

            if (gi == MAX_POINTS - 1)
            begin : g_tail
                assign rv = cell_val[gi];
            end
            else
            begin : g_mid
                assign rv = cell_val[gi+1];
            end

            rmca_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl),
                .pos       (pos),
                .valid     (cell_valid[gi]),
                .left_keep (lk),
                .left_val  (lv),
                .right_val (rv),
                .val       (cell_val[gi]),
                .keep      (cell_keep[gi])
            );
        end
    endgenerate

    rmca_gap u_gap (
        .clk  (clk),
        .ctl  (gap_ctl),
        .head (cell_val[0]),
        .ring (ring_reg),
        .span (span)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_span_next  = out_span_reg;
        out_ovf_next   = out_ovf_reg;
        cell_ctl       = '0;
        gap_ctl        = '0;
        s_axis_tready  = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (count_reg < CNT_W'(MAX_POINTS))
                    begin
                        cell_ctl.ins = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cell_ctl.shift = 1'b1;
                if (scan_reg == '0)
                begin
                    gap_ctl.load_first = 1'b1;
                end
                else
                begin
                    gap_ctl.step = 1'b1;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == count_reg - 1'b1)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                gap_ctl.wrap = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                gap_ctl.fin = 1'b1;
                state_next  = ST_SEND;
            end
            ST_SEND:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_span_next  = (count_reg <= CNT_W'(1)) ? '0 : span;
                    out_ovf_next   = ovf_reg;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            ovf_reg       <= 1'b0;
            ring_reg      <= POS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                ring_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_span_reg <= out_span_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(DATA_W - POS_W){1'b0}}, out_span_reg};
    assign m_axis_tuser  = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tlast |=> state_reg == ST_SCAN)
        else $error("last beat did not start the scan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_reg < count_reg)
        else $error("scan walked past the stored points");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_axis_tlast && count_reg < CNT_W'(MAX_POINTS)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted point not counted");

endmodule

### test/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rmca_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam logic [POS_W-1:0] RING_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_point;
        logic [3:0]       gap;
    } point_beat_t;

    typedef struct packed {
        logic [POS_W-1:0] min_span;
        logic             overflow;
    } arc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [29:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // position[29:0], zero pad
    logic        s_axis_tlast = 1'b0;  // last_point
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // min_span[29:0], zero pad
    logic        m_axis_tuser;         // overflow

    // predictor state
    logic [POS_W-1:0] ring_now = POS_W'(1);
    logic [POS_W-1:0] held_pos [STORE_DEPTH];
    int               held_count = 0;
    logic             held_overflow = 1'b0;

    point_beat_t point_queue [$];
    arc_result_t span_expect [$];

    int   items_queued = 0;
    int   items_taken = 0;
    int   random_items = 0;
    int   mismatches = 0;
    logic send_calm = 1'b0;
    logic recv_calm = 1'b0;

    ring_min_covering_arc #(
        .MAX_POINTS(STORE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [POS_W-1:0] arc_span();
        longint widest;
        longint g;
        longint span;
        int     i;
        if (held_count <= 1)
            return '0;
        widest = longint'(ring_now) - longint'(held_pos[held_count-1])
                 + longint'(held_pos[0]);
        for (i = 0; i + 1 < held_count; i++)
        begin
            g = longint'(held_pos[i+1]) - longint'(held_pos[i]);
            if (g > widest)
                widest = g;
        end
        span = longint'(ring_now) - widest;
        if (span < 0)
            span = 0;
        return span[POS_W-1:0];
    endfunction

    function automatic void absorb_point(input point_beat_t b);
        int          slot;
        arc_result_t r;
        if (held_count < STORE_DEPTH)
        begin
            slot = held_count;
            while (slot > 0 && held_pos[slot-1] > b.position)
            begin
                held_pos[slot] = held_pos[slot-1];
                slot--;
            end
            held_pos[slot] = b.position;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (b.last_point)
        begin
            r.min_span = arc_span();
            r.overflow = held_overflow;
            span_expect.push_back(r);
            held_count = 0;
            held_overflow = 1'b0;
        end
    endfunction

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endfunction

    // input driver
    point_beat_t drv_item;
    logic        drv_loaded = 1'b0;
    int          drv_wait = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            drv_loaded = 1'b0;
            drv_wait = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_point(drv_item);
                items_taken++;
                drv_loaded = 1'b0;
            end
            if (!drv_loaded && point_queue.size() != 0)
            begin
                drv_item = point_queue.pop_front();
                drv_wait = int'(drv_item.gap);
                drv_loaded = 1'b1;
            end
            if (drv_loaded && drv_wait == 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, drv_item.position};
                s_axis_tlast  <= drv_item.last_point;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                if (drv_loaded)
                    drv_wait--;
            end
        end
    end

    // result monitor
    int          rcv_wait = 0;
    arc_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rcv_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (span_expect.size() == 0)
                    flag_error($sformatf("unexpected beat: min_span %0d overflow %0b",
                                         m_axis_tdata[29:0], m_axis_tuser));
                else
                begin
                    want = span_expect.pop_front();
                    if (m_axis_tdata[29:0] !== want.min_span)
                        flag_error($sformatf("min_span mismatch: expected %0d, got %0d",
                                             want.min_span, m_axis_tdata[29:0]));
                    if (m_axis_tuser !== want.overflow)
                        flag_error($sformatf("overflow mismatch: expected %0b, got %0b",
                                             want.overflow, m_axis_tuser));
                end
                rcv_wait = recv_calm ? 0 : $urandom_range(14, 0);
            end
            if (rcv_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rcv_wait--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_point(input logic [POS_W-1:0] position, input logic last_point);
        point_beat_t b;
        b.position = position;
        b.last_point = last_point;
        b.gap = send_calm ? 4'd0 : 4'($urandom_range(14, 0));
        point_queue.push_back(b);
        items_queued++;
    endtask

    task automatic queue_random_set(input int n);
        logic [31:0]      rnd;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] prev;
        int               k;
        prev = POS_W'(1);
        for (k = 0; k < n; k++)
        begin
            rnd = $urandom();
            case ($urandom_range(9, 0))
                0: p = rnd[POS_W-1:0];
                1: p = prev;
                2: p = rnd[0] ? POS_W'(1) : ring_now;
                default: p = POS_W'($urandom_range(ring_now, 1));
            endcase
            queue_point(p, k == n - 1);
            prev = p;
        end
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || span_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_ring(input logic [POS_W-1:0] value);
        wait_idle();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        ring_now = value;
    endtask

    initial
    begin
        logic [31:0]      rnd;
        logic [POS_W-1:0] ring_pick;
        int               s;
        int               n;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ring size still at its reset value
        queue_point(1, 1'b1);
        queue_point(1, 1'b0);
        queue_point(1, 1'b1);

        set_ring(RING_MAX);
        queue_point(RING_MAX, 1'b1);
        queue_point(1, 1'b0);
        queue_point(RING_MAX, 1'b1);
        queue_point(RING_MAX, 1'b0);
        queue_point(0, 1'b0);
        queue_point(30'h2AAAAAAA, 1'b0);
        queue_point(30'h15555555, 1'b1);
        queue_point(9, 1'b0);
        queue_point(9, 1'b0);
        queue_point(9, 1'b1);

        // positions beyond the ring, negative wrap and saturation
        set_ring(10);
        queue_point(RING_MAX, 1'b0);
        queue_point(3, 1'b1);
        queue_point(15, 1'b0);
        queue_point(12, 1'b1);
        queue_point(10, 1'b0);
        queue_point(1, 1'b0);
        queue_point(5, 1'b1);

        set_ring(30'h0ABCDE);
        queue_random_set(5);

        while (random_items < 600)
        begin
            rnd = $urandom();
            case ($urandom_range(5, 0))
                0: ring_pick = POS_W'(1);
                1: ring_pick = RING_MAX;
                2: ring_pick = POS_W'($urandom_range(16, 2));
                3: ring_pick = POS_W'($urandom_range(5000, 17));
                default: ring_pick = (rnd[POS_W-1:0] == 0) ? POS_W'(1) : rnd[POS_W-1:0];
            endcase
            set_ring(ring_pick);
            send_calm = ($urandom_range(3, 0) == 0);
            recv_calm = ($urandom_range(3, 0) == 0);
            for (s = 0; s < 8; s++)
            begin
                n = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 9) : $urandom_range(8, 1);
                queue_random_set(n);
                random_items += n;
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && span_expect.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/rmca_pkg.sv
rtl/rmca_cell.sv
rtl/rmca_gap.sv
rtl/ring_min_covering_arc.sv
test/testbench.sv
